// ===== sv/pfb_pkg.sv =====
package pfb_pkg;

	// Storage geometry.
	localparam int REC_AW = 12;
	localparam int SEQ_AW = 10;
	localparam int PK_AW = 16;
	localparam logic [REC_AW:0] MAX_RECORDS = 13'd4096;
	localparam logic [SEQ_AW:0] MAX_SEQUENCES = 11'd1024;
	localparam logic [6:0] MAX_FETCH = 7'd64;
	localparam int POS_W = 48;

	// Function codes of an input transaction.
	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_BYTE = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;

	// Code returned for an ambiguous position.
	localparam logic [2:0] CODE_N = 3'd4;

	typedef struct packed {
		logic [1:0] func;
		logic starts_sequence;
		logic [31:0] gap_length;
		logic [31:0] run_length;
		logic [15:0] byte_address;
		logic [7:0] byte_value;
		logic [9:0] sequence_index;
		logic [31:0] sequence_offset;
		logic [6:0] base_count;
	} req_t;

	typedef struct packed {
		logic [2:0] base_code;
		logic last_of_run;
		logic error_flag;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_APPEND,
		CMD_BYTE,
		CMD_FETCH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic starts_sequence;
		logic [31:0] gap_length;
		logic [31:0] run_length;
		logic [15:0] byte_address;
		logic [7:0] byte_value;
		logic [9:0] sequence_index;
		logic [31:0] sequence_offset;
		logic [6:0] base_count;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ERR,
		B_SEQ_RD,
		B_SEQ_SET,
		B_REC_RD,
		B_DEC,
		B_PK_RD,
		B_PK_EMIT
	} back_state_t;

endpackage

// ===== sv/pfb_front.sv =====
module pfb_front import pfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic cmd_valid,
	output cmd_t cmd,
	input logic cmd_pop
);

	cmd_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic keep;
	logic push;
	cmd_t cls;

	// Classify the transaction; unused codes and empty fetches are dropped here.
	always_comb begin
		cls.kind = CMD_APPEND;
		keep = 1'b0;
		unique case (req.func)
			FUNC_APPEND: begin
				cls.kind = CMD_APPEND;
				keep = 1'b1;
			end
			FUNC_BYTE: begin
				cls.kind = CMD_BYTE;
				keep = 1'b1;
			end
			FUNC_FETCH: begin
				cls.kind = CMD_FETCH;
				keep = (req.base_count != 7'd0);
			end
			default: begin
				cls.kind = CMD_APPEND;
				keep = 1'b0;
			end
		endcase
		cls.starts_sequence = req.starts_sequence;
		cls.gap_length = req.gap_length;
		cls.run_length = req.run_length;
		cls.byte_address = req.byte_address;
		cls.byte_value = req.byte_value;
		cls.sequence_index = req.sequence_index;
		cls.sequence_offset = req.sequence_offset;
		cls.base_count = (req.base_count > MAX_FETCH) ? MAX_FETCH : req.base_count;
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push = req_valid && !req_stall && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	// Two-entry command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// ===== sv/pfb_back.sv =====
module pfb_back import pfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	logic [31:0] gap_mem [2**REC_AW];
	logic [31:0] run_mem [2**REC_AW];
	logic [REC_AW:0] first_mem [2**SEQ_AW];
	logic [31:0] bstart_mem [2**SEQ_AW];
	logic [7:0] pk_mem [2**PK_AW];

	back_state_t state_q, state_d;
	logic [REC_AW:0] rec_total_q;
	logic [SEQ_AW:0] seq_total_q;
	logic [31:0] run_total_q;

	logic [SEQ_AW-1:0] seq_q;
	logic [REC_AW:0] r_q;
	logic [REC_AW:0] stop_q;
	logic [31:0] addr_q;
	logic [POS_W-1:0] at_q;
	logic [32:0] pos_q;
	logic [6:0] k_q;
	logic [6:0] count_q;
	logic [31:0] a_q;

	logic [31:0] gap_rd_q, run_rd_q, bstart_rd_q;
	logic [REC_AW:0] first_rd_q, first2_rd_q;
	logic [7:0] pk_rd_q;

	logic out_free;
	logic append_err, fetch_err;
	logic append_we, byte_we;
	logic emit;
	rsp_t emit_data;
	logic [POS_W-1:0] pos_x, gap_end, run_end, offs;
	logic [SEQ_AW:0] seq_next;
	logic last;
	logic [1:0] pk_code;

	assign out_free = !rsp_valid || !rsp_stall;
	assign append_err = (rec_total_q == MAX_RECORDS) ||
		(rec_total_q == '0 && !cmd.starts_sequence) ||
		(cmd.starts_sequence && seq_total_q == MAX_SEQUENCES);
	assign fetch_err = ({1'b0, cmd.sequence_index} >= seq_total_q);
	assign pos_x = {{(POS_W-33){1'b0}}, pos_q};
	assign gap_end = at_q + {{(POS_W-32){1'b0}}, gap_rd_q};
	assign run_end = gap_end + {{(POS_W-32){1'b0}}, run_rd_q};
	assign offs = pos_x - gap_end;
	assign seq_next = {1'b0, seq_q} + 1'b1;
	assign last = (k_q + 7'd1 == count_q);
	assign pk_code = 2'(pk_rd_q >> {a_q[1:0], 1'b0});

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_APPEND: state_d = append_err ? B_ERR : B_IDLE;
						CMD_FETCH: state_d = fetch_err ? B_ERR : B_SEQ_RD;
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_ERR: state_d = out_free ? B_IDLE : B_ERR;
			B_SEQ_RD: state_d = B_SEQ_SET;
			B_SEQ_SET: state_d = B_REC_RD;
			B_REC_RD: state_d = B_DEC;
			B_DEC: begin
				if (r_q >= stop_q || pos_x < gap_end) begin
					if (out_free && last) begin
						state_d = B_IDLE;
					end
				end else if (pos_x < run_end) begin
					state_d = B_PK_RD;
				end else begin
					state_d = B_REC_RD;
				end
			end
			B_PK_RD: state_d = B_PK_EMIT;
			B_PK_EMIT: begin
				if (out_free) begin
					state_d = last ? B_IDLE : B_DEC;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cmd_pop = 1'b0;
		append_we = 1'b0;
		byte_we = 1'b0;
		emit = 1'b0;
		emit_data = '0;
		unique case (state_q)
			B_IDLE: begin
				cmd_pop = cmd_valid;
				append_we = cmd_valid && cmd.kind == CMD_APPEND && !append_err;
				byte_we = cmd_valid && cmd.kind == CMD_BYTE;
			end
			B_ERR: begin
				emit = out_free;
				emit_data.last_of_run = 1'b1;
				emit_data.error_flag = 1'b1;
			end
			B_DEC: begin
				if (r_q >= stop_q || pos_x < gap_end) begin
					emit = out_free;
					emit_data.base_code = CODE_N;
					emit_data.last_of_run = last;
				end
			end
			B_PK_EMIT: begin
				emit = out_free;
				emit_data.base_code = (a_q[31:PK_AW+2] != '0) ? 3'd0 : {1'b0, pk_code};
				emit_data.last_of_run = last;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control registers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rec_total_q <= '0;
			seq_total_q <= '0;
			run_total_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (append_we) begin
				rec_total_q <= rec_total_q + 1'b1;
				run_total_q <= run_total_q + cmd.run_length;
				if (cmd.starts_sequence) begin
					seq_total_q <= seq_total_q + 1'b1;
				end
			end
			if (emit) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Fetch walk datapath and output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp <= emit_data;
		end
		if (state_q == B_IDLE && cmd_valid) begin
			seq_q <= cmd.sequence_index;
			pos_q <= {1'b0, cmd.sequence_offset};
			count_q <= cmd.base_count;
			k_q <= '0;
		end
		if (state_q == B_SEQ_SET) begin
			r_q <= first_rd_q;
			stop_q <= (seq_next < seq_total_q) ? first2_rd_q : rec_total_q;
			addr_q <= bstart_rd_q;
			at_q <= '0;
		end
		if (state_q == B_DEC && !(r_q >= stop_q || pos_x < gap_end)) begin
			if (pos_x < run_end) begin
				a_q <= addr_q + offs[31:0];
			end else begin
				at_q <= run_end;
				addr_q <= addr_q + run_rd_q;
				r_q <= r_q + 1'b1;
			end
		end
		if (emit && state_q != B_ERR) begin
			k_q <= k_q + 7'd1;
			pos_q <= pos_q + 33'd1;
		end
	end

	// Record tables.
	always_ff @(posedge clk) begin
		if (append_we) begin
			gap_mem[rec_total_q[REC_AW-1:0]] <= cmd.gap_length;
			run_mem[rec_total_q[REC_AW-1:0]] <= cmd.run_length;
		end
		gap_rd_q <= gap_mem[r_q[REC_AW-1:0]];
		run_rd_q <= run_mem[r_q[REC_AW-1:0]];
	end

	// Sequence tables.
	always_ff @(posedge clk) begin
		if (append_we && cmd.starts_sequence) begin
			first_mem[seq_total_q[SEQ_AW-1:0]] <= rec_total_q;
			bstart_mem[seq_total_q[SEQ_AW-1:0]] <= run_total_q;
		end
		first_rd_q <= first_mem[seq_q];
		first2_rd_q <= first_mem[seq_next[SEQ_AW-1:0]];
		bstart_rd_q <= bstart_mem[seq_q];
	end

	// Packed base store.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			pk_mem[cmd.byte_address] <= cmd.byte_value;
		end
		pk_rd_q <= pk_mem[a_q[PK_AW+1:2]];
	end

endmodule

// ===== sv/packed_reference_base_fetch.sv =====
// Packed reference base fetch.
// The req channel carries one transaction per item: append a record, write a
// packed byte of four 2-bit bases, or fetch up to 64 bases of a sequence.
// The rsp channel returns one transaction per fetched base, with last_of_run
// set on the final one, or a single error transaction for a rejected request.
// Accepted appends and byte writes give no response. A fetch reads the
// sequence tables (B_SEQ_RD, B_SEQ_SET), then walks the record table through
// its single read port (B_REC_RD, B_DEC) and emits each base, reading packed
// bytes in a run (B_PK_RD, B_PK_EMIT). A two-entry queue parts the front
// from the back, so new requests are taken while a fetch is in progress.
// Reset clears the record, sequence and base counters and the queue; the
// tables themselves are not cleared. A stalled response holds in the output
// register and the walk waits until it is taken.
module packed_reference_base_fetch import pfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	pfb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	pfb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pfb_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 250;
	localparam int QUIET_ITEMS = 30;

	// Row checks of the directed table.
	localparam bit ROW_PREDICT = 1'b0;
	localparam bit ROW_REJECT = 1'b1;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	packed_reference_base_fetch i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block's tables and counters.
	logic [31:0] gap_tab [4096];
	logic [31:0] run_tab [4096];
	logic [12:0] seq_first [1024];
	logic [31:0] seq_base [1024];
	logic [7:0] pk_store [65536];
	bit pk_written [65536];
	int unsigned rec_count;
	int unsigned seq_count;
	logic [31:0] base_total;

	rsp_t expected_bases [$];
	int errors;
	bit quiet;
	int idle_cycles;
	int stall_left;

	task automatic flag_mismatch(input string msg);
		begin
			errors++;
			$display("tb_top: mismatch: %s", msg);
		end
	endtask

	// Appends one expected transaction at the tail of the queue.
	function automatic void queue_expected(input rsp_t e);
		begin
			expected_bases.insert(expected_bases.size(), e);
		end
	endfunction

	// Base code at a position of a sequence; bix is the packed byte read or -1.
	function automatic logic [2:0] code_at(input int unsigned s, input longint unsigned pos,
			output int bix);
		int unsigned stop;
		int unsigned r;
		longint unsigned at;
		logic [31:0] addr;
		logic [31:0] a;
		logic [7:0] b;
		begin
			bix = -1;
			stop = (s + 1 < seq_count) ? seq_first[s + 1] : rec_count;
			addr = seq_base[s];
			at = 0;
			for (r = seq_first[s]; r < stop; r++) begin
				at += gap_tab[r];
				if (pos < at)
					return CODE_N;
				if (pos < at + run_tab[r]) begin
					a = addr + 32'(pos - at);
					b = 8'd0;
					if (a[31:2] < 65536) begin
						bix = int'(a[31:2]);
						b = pk_store[bix];
					end
					return {1'b0, b[a[1:0] * 2 +: 2]};
				end
				at += run_tab[r];
				addr += run_tab[r];
			end
			return CODE_N;
		end
	endfunction

	function automatic rsp_t reject_rsp();
		rsp_t e;
		begin
			e.base_code = 3'd0;
			e.last_of_run = 1'b1;
			e.error_flag = 1'b1;
			return e;
		end
	endfunction

	// Applies one transaction to the shadow state and queues its results.
	function automatic void predict_bases(input req_t r);
		int unsigned cnt;
		int unsigned k;
		int bix;
		rsp_t e;
		begin
			case (r.func)
				FUNC_APPEND: begin
					if (rec_count >= 4096 || (rec_count == 0 && !r.starts_sequence) ||
							(r.starts_sequence && seq_count >= 1024)) begin
						queue_expected(reject_rsp());
					end else begin
						gap_tab[rec_count] = r.gap_length;
						run_tab[rec_count] = r.run_length;
						if (r.starts_sequence) begin
							seq_first[seq_count] = 13'(rec_count);
							seq_base[seq_count] = base_total;
							seq_count++;
						end
						base_total += r.run_length;
						rec_count++;
					end
				end
				FUNC_BYTE: begin
					pk_store[r.byte_address] = r.byte_value;
					pk_written[r.byte_address] = 1'b1;
				end
				FUNC_FETCH: begin
					if (r.sequence_index >= seq_count) begin
						queue_expected(reject_rsp());
					end else begin
						cnt = (r.base_count > MAX_FETCH) ? MAX_FETCH : r.base_count;
						for (k = 0; k < cnt; k++) begin
							e.base_code = code_at(r.sequence_index,
								longint'(r.sequence_offset) + k, bix);
							e.last_of_run = (k + 1 == cnt);
							e.error_flag = 1'b0;
							queue_expected(e);
						end
					end
				end
				default: ;
			endcase
		end
	endfunction

	task automatic go_idle(input int n);
		begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drives one transaction and holds it until it is taken.
	task automatic send_raw(input req_t r);
		begin
			if (!quiet && $urandom_range(0, 5) == 0)
				go_idle($urandom_range(1, 15));
			req_valid <= 1'b1;
			req <= r;
			do @(posedge clk); while (req_stall);
		end
	endtask

	task automatic send_byte(input int unsigned addr, input logic [7:0] val);
		req_t r;
		begin
			r = '0;
			r.func = FUNC_BYTE;
			r.byte_address = 16'(addr);
			r.byte_value = val;
			predict_bases(r);
			send_raw(r);
		end
	endtask

	// A fetch must never read a packed byte that was never written.
	task automatic fill_fetch_bytes(input req_t r);
		int unsigned cnt;
		int unsigned k;
		int bix;
		begin
			if (r.func == FUNC_FETCH && r.sequence_index < seq_count) begin
				cnt = (r.base_count > MAX_FETCH) ? MAX_FETCH : r.base_count;
				for (k = 0; k < cnt; k++) begin
					void'(code_at(r.sequence_index, longint'(r.sequence_offset) + k, bix));
					if (bix >= 0 && !pk_written[bix])
						send_byte(bix, 8'($urandom));
				end
			end
		end
	endtask

	task automatic send_checked(input req_t r);
		begin
			fill_fetch_bytes(r);
			predict_bases(r);
			send_raw(r);
		end
	endtask

	function automatic req_t mk_append(input bit st, input logic [31:0] g, input logic [31:0] n);
		req_t r;
		begin
			r = '0;
			r.func = FUNC_APPEND;
			r.starts_sequence = st;
			r.gap_length = g;
			r.run_length = n;
			return r;
		end
	endfunction

	function automatic req_t mk_fetch(input int unsigned s, input logic [31:0] off,
			input int unsigned cnt);
		req_t r;
		begin
			r = '0;
			r.func = FUNC_FETCH;
			r.sequence_index = 10'(s);
			r.sequence_offset = off;
			r.base_count = 7'(cnt);
			return r;
		end
	endfunction

	function automatic req_t mk_byte(input int unsigned addr, input logic [7:0] val);
		req_t r;
		begin
			r = '0;
			r.func = FUNC_BYTE;
			r.byte_address = 16'(addr);
			r.byte_value = val;
			return r;
		end
	endfunction

	// Random transaction with every field filled, biased toward useful content.
	task automatic send_random();
		req_t r;
		logic [31:0] big;
		int unsigned pick;
		begin
			r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				r.func = FUNC_APPEND;
				r.starts_sequence = (seq_count == 0) || ($urandom_range(0, 2) == 0);
				r.gap_length = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
				r.run_length = $urandom_range(0, 12);
				if ($urandom_range(0, 9) == 0) begin
					// A huge run, then one that wraps the base total back.
					big = $urandom;
					r.run_length = big;
					send_checked(r);
					r.starts_sequence = 1'b0;
					r.gap_length = $urandom_range(0, 3);
					r.run_length = -big + $urandom_range(0, 8);
				end
			end else if (pick < 50) begin
				r.func = FUNC_BYTE;
			end else if (pick < 95) begin
				r.func = FUNC_FETCH;
				if (seq_count > 0 && $urandom_range(0, 9) != 0)
					r.sequence_index = $urandom_range(0, seq_count - 1);
				if ($urandom_range(0, 7) != 0) begin
					r.sequence_offset = $urandom_range(0, 40);
					r.base_count = $urandom_range(1, 64);
				end
			end else begin
				r.func = FUNC_UNUSED;
			end
			send_checked(r);
		end
	endtask

	typedef struct {
		req_t r;
		bit check;
	} row_t;

	row_t plan [$];

	// Adds one row at the end of the directed table.
	function automatic void add_row(input req_t r, input bit chk);
		row_t w;
		begin
			w.r = r;
			w.check = chk;
			plan.insert(plan.size(), w);
		end
	endfunction

	// Response checker.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_bases.size() == 0) begin
				flag_mismatch($sformatf("unexpected transaction %p", rsp));
			end else begin
				e = expected_bases.pop_front();
				if (rsp.base_code !== e.base_code)
					flag_mismatch($sformatf("base_code %0d, want %0d", rsp.base_code,
						e.base_code));
				if (rsp.last_of_run !== e.last_of_run)
					flag_mismatch($sformatf("last_of_run %b, want %b", rsp.last_of_run,
						e.last_of_run));
				if (rsp.error_flag !== e.error_flag)
					flag_mismatch($sformatf("error_flag %b, want %b", rsp.error_flag,
						e.error_flag));
			end
		end
	end

	// Receiver stalls in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		errors = 0;
		quiet = 1'b0;
		idle_cycles = 0;
		stall_left = 0;
		rec_count = 0;
		seq_count = 0;
		base_total = '0;
		for (i = 0; i < 65536; i++)
			pk_written[i] = 1'b0;

		// Directed table: empty-block rejects, extremes and the special cases.
		add_row(mk_fetch(0, 0, 1), ROW_REJECT);
		add_row(mk_append(1'b0, 2, 3), ROW_REJECT);
		add_row(mk_append(1'b1, 0, 8), ROW_PREDICT);
		add_row(mk_append(1'b0, 3, 5), ROW_PREDICT);
		add_row(mk_append(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), ROW_PREDICT);
		add_row(mk_append(1'b0, 0, 1), ROW_PREDICT);
		add_row(mk_byte(0, 8'h00), ROW_PREDICT);
		add_row(mk_byte(1, 8'hFF), ROW_PREDICT);
		add_row(mk_byte(2, 8'hE4), ROW_PREDICT);
		add_row(mk_byte(3, 8'h1B), ROW_PREDICT);
		add_row(mk_byte(16'hFFFF, 8'hA5), ROW_PREDICT);
		add_row(mk_fetch(0, 0, 64), ROW_PREDICT);
		add_row(mk_fetch(0, 10, 0), ROW_PREDICT);
		add_row(mk_fetch(0, 0, 127), ROW_PREDICT);
		add_row(mk_fetch(1, 32'hFFFF_FFFF, 64), ROW_PREDICT);
		add_row(mk_fetch(1, 0, 8), ROW_PREDICT);
		add_row(mk_fetch(1023, 0, 4), ROW_REJECT);
		add_row(mk_fetch(2, 0, 4), ROW_REJECT);
		add_row(mk_append(1'b1, 1, 4), ROW_PREDICT);
		add_row(mk_fetch(2, 0, 10), ROW_PREDICT);
		add_row(mk_fetch(2, 32'hFFFF_FFFF, 3), ROW_PREDICT);
		plan[plan.size() - 1].r.func = FUNC_FETCH;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[j]) begin
			if (plan[j].check == ROW_REJECT) begin
				queue_expected(reject_rsp());
				send_raw(plan[j].r);
			end else begin
				send_checked(plan[j].r);
			end
		end
		begin
			req_t r3;
			r3 = '1;
			r3.func = FUNC_UNUSED;
			send_checked(r3);
		end

		// Random traffic with one full drain in the middle.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				req_valid <= 1'b0;
				do @(posedge clk); while (expected_bases.size() != 0);
			end
			send_random();
		end

		// Final stretch without idling on either side.
		quiet = 1'b1;
		for (i = 0; i < QUIET_ITEMS; i++)
			send_checked(mk_fetch($urandom_range(0, seq_count), $urandom_range(0, 20),
				$urandom_range(1, 64)));

		req_valid <= 1'b0;
		while (expected_bases.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pfb_pkg.sv
sv/pfb_front.sv
sv/pfb_back.sv
sv/packed_reference_base_fetch.sv
verif/tb_top.sv
